/* rtl/rc4_pkg.sv */
// ============================================================================
// RC4 cipher package
// Shared types for the RC4 cipher engine: the controller states and the
// request bundle that drives the state table memory.
// ============================================================================
`default_nettype none

package rc4_pkg;

    localparam int unsigned TBL_AW = 8;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DJ,
        ST_DR,
        ST_DOUT,
        ST_KRD,
        ST_KACC,
        ST_KSW1,
        ST_KSW2
    } state_t;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [TBL_AW-1:0] rd_addr;
        logic              wr_en;
        logic [TBL_AW-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } sbox_req_t;

endpackage

`default_nettype wire

/* rtl/rc4_sbox.sv */
// ============================================================================
// RC4 state table
// 256-entry byte memory with one registered read port and one write port.
// Per-entry valid bits make an unwritten entry read as its own address, so a
// single clear restores the identity permutation.
// ============================================================================
`default_nettype none

module rc4_sbox (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rc4_pkg::sbox_req_t req,
    output logic [rc4_pkg::BYTE_W-1:0] rd_data
);

    localparam int unsigned DEPTH = 2 ** rc4_pkg::TBL_AW;

    logic [rc4_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           vld_reg;
    logic [rc4_pkg::BYTE_W-1:0] mem_q_reg;
    logic                       hit_q_reg;
    logic [rc4_pkg::TBL_AW-1:0] addr_q_reg;

    // Valid bits: cleared at once, set by each write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.clear)
        begin
            vld_reg <= '0;
        end
        else if (req.wr_en)
        begin
            vld_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read data is registered and held until the next read.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            mem_q_reg  <= mem[req.rd_addr];
            hit_q_reg  <= vld_reg[req.rd_addr];
            addr_q_reg <= req.rd_addr;
        end
    end

    assign rd_data = hit_q_reg ? mem_q_reg : addr_q_reg;

endmodule

`default_nettype wire

/* rtl/rc4_stream_cipher.sv */
// ============================================================================
// RC4 stream cipher engine
// Loads a key byte by byte, runs the RC4 key schedule and encrypts or
// decrypts one data byte per item with the keystream.
// ============================================================================
// Sequencing:
//   An accepted data item steps through ST_DJ, ST_DR and ST_DOUT; its result
//   enters the output register as ST_DOUT ends, and only then does ST_IDLE
//   accept the next item; the single table read port and write port set this.
//   A full output register holds the last data step until the result leaves.
//   A key byte without tlast is taken in ST_IDLE, which stays ready. A key byte
//   with tlast runs the schedule: 256 swaps via ST_KRD, ST_KACC, ST_KSW1, ST_KSW2.
// Reset clears all control state; the state table reads as the identity.
// ============================================================================
`default_nettype none

module rc4_stream_cipher #(
    parameter int unsigned MAX_KEY_BYTES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] key_byte, [15:8] data_byte
    input  wire logic        s_tuser,   // [0] cmd: 0 = key byte, 1 = data byte
    input  wire logic        s_tlast,   // key_last

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [7:0] out_byte
);

    // Key store address width and key count width follow the key length limit.
    localparam int unsigned KA_W  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int unsigned PW    = KA_W + 1;

    localparam logic [CNT_W-1:0] KEY_LIMIT = CNT_W'(MAX_KEY_BYTES);
    localparam logic [7:0]       LAST_STEP = 8'hFF;

    rc4_pkg::state_t    state_reg, state_next;
    rc4_pkg::sbox_req_t sreq;
    logic [7:0]         sdata;

    logic [7:0]       i_reg, i_next;
    logic [7:0]       j_reg, j_next;
    logic [7:0]       si_reg, si_next;     // S[i] in data mode, S[n] in schedule
    logic [7:0]       sj_reg, sj_next;
    logic [7:0]       r_reg, r_next;
    logic [7:0]       data_reg, data_next;
    logic [7:0]       acc_reg, acc_next;
    logic [7:0]       n_reg, n_next;
    logic [KA_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0] key_count_reg, key_count_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;

    logic [7:0]       key_mem [MAX_KEY_BYTES];
    logic [7:0]       key_q_reg;
    logic             key_wr;

    logic             in_acc;
    logic [7:0]       ks;
    logic [PW-1:0]    pos_inc;

    assign in_acc  = s_tvalid && s_tready;
    assign key_wr  = in_acc && !s_tuser && (key_count_reg < KEY_LIMIT);
    assign pos_inc = {1'b0, pos_reg} + PW'(1);

    // Keystream byte: S[r] after the swap. The swap writes may still be in
    // flight, so an address that matches either swapped entry is forwarded.
    always_comb
    begin
        if (r_reg == j_reg)
        begin
            ks = si_reg;
        end
        else if (r_reg == i_reg)
        begin
            ks = sj_reg;
        end
        else
        begin
            ks = sdata;
        end
    end

    rc4_sbox u_sbox (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sreq),
        .rd_data (sdata)
    );

    // Key store: written on key items while it has room, read once per schedule step.
    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            key_mem[key_count_reg[KA_W-1:0]] <= s_tdata[7:0];
        end
        if (state_reg == rc4_pkg::ST_KRD)
        begin
            key_q_reg <= key_mem[pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            acc_reg       <= '0;
            n_reg         <= '0;
            pos_reg       <= '0;
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            acc_reg       <= acc_next;
            n_reg         <= n_next;
            pos_reg       <= pos_next;
            key_count_reg <= key_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        r_reg        <= r_next;
        data_reg     <= data_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        r_next         = r_reg;
        data_next      = data_reg;
        acc_next       = acc_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        key_count_next = key_count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sreq           = '0;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_acc)
                begin
                    if (s_tuser)
                    begin
                        // Data item: advance i and fetch S[i].
                        i_next       = i_reg + 8'd1;
                        data_next    = s_tdata[15:8];
                        sreq.rd_en   = 1'b1;
                        sreq.rd_addr = i_reg + 8'd1;
                        state_next   = rc4_pkg::ST_DJ;
                    end
                    else
                    begin
                        if (key_wr)
                        begin
                            key_count_next = key_count_reg + CNT_W'(1);
                        end
                        if (s_tlast)
                        begin
                            // Back to the identity table, then schedule.
                            sreq.clear = 1'b1;
                            n_next     = '0;
                            pos_next   = '0;
                            acc_next   = '0;
                            state_next = rc4_pkg::ST_KRD;
                        end
                    end
                end
            end

            rc4_pkg::ST_DJ:
            begin
                si_next      = sdata;
                j_next       = j_reg + sdata;
                sreq.rd_en   = 1'b1;
                sreq.rd_addr = j_reg + sdata;
                state_next   = rc4_pkg::ST_DR;
            end

            rc4_pkg::ST_DR:
            begin
                sj_next      = sdata;
                sreq.wr_en   = 1'b1;
                sreq.wr_addr = i_reg;
                sreq.wr_data = sdata;
                r_next       = si_reg + sdata;
                sreq.rd_en   = 1'b1;
                sreq.rd_addr = si_reg + sdata;
                state_next   = rc4_pkg::ST_DOUT;
            end

            rc4_pkg::ST_DOUT:
            begin
                // Second half of the swap; repeating it while stalled is harmless.
                sreq.wr_en   = 1'b1;
                sreq.wr_addr = j_reg;
                sreq.wr_data = si_reg;
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = data_reg ^ ks;
                    state_next     = rc4_pkg::ST_IDLE;
                end
            end

            rc4_pkg::ST_KRD:
            begin
                sreq.rd_en   = 1'b1;
                sreq.rd_addr = n_reg;
                state_next   = rc4_pkg::ST_KACC;
            end

            rc4_pkg::ST_KACC:
            begin
                si_next      = sdata;
                acc_next     = acc_reg + sdata + key_q_reg;
                sreq.rd_en   = 1'b1;
                sreq.rd_addr = acc_reg + sdata + key_q_reg;
                state_next   = rc4_pkg::ST_KSW1;
            end

            rc4_pkg::ST_KSW1:
            begin
                sreq.wr_en   = 1'b1;
                sreq.wr_addr = n_reg;
                sreq.wr_data = sdata;
                state_next   = rc4_pkg::ST_KSW2;
            end

            rc4_pkg::ST_KSW2:
            begin
                sreq.wr_en   = 1'b1;
                sreq.wr_addr = acc_reg;
                sreq.wr_data = si_reg;
                n_next       = n_reg + 8'd1;
                if (pos_inc >= PW'(key_count_reg))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_inc[KA_W-1:0];
                end
                if (n_reg == LAST_STEP)
                begin
                    i_next         = '0;
                    j_next         = '0;
                    key_count_next = '0;
                    state_next     = rc4_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4_pkg::ST_KRD;
                end
            end

            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The table clear must never collide with a write, or the write is lost.
    a_clear_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(sreq.clear && sreq.wr_en))
        else $error("state table clear coincides with a write");

    // A finished key load always leaves a nonzero key count, so the schedule never runs empty.
    a_key_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !s_tuser && s_tlast) |=> (key_count_reg != '0))
        else $error("key schedule started with an empty key");

    // The last schedule step leaves both indices and the key count cleared.
    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_KSW2 && n_reg == LAST_STEP)
        |=> (i_reg == '0 && j_reg == '0 && key_count_reg == '0))
        else $error("indices not cleared after key schedule");

    // A result appears only at the end of a data item.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == rc4_pkg::ST_DOUT))
        else $error("result raised outside the output step");

endmodule

`default_nettype wire

/* dv/rc4_stream_cipher_tb.sv */
// ============================================================================
// RC4 stream cipher engine testbench
// Feeds key bytes and data bytes into the cipher over the input stream and
// checks every output byte against a bit-exact RC4 predictor. A short table
// of directed items comes first: reset keystream, single-byte keys at both
// extremes, multi-byte keys, rekeying in mid-stream and ignored fields. A
// random part follows, built mostly of complete key loads followed by data
// bursts, with full-length and overlong keys among them, plus loose noise
// items. Both stream sides stall at random, except near the end of the run.
// ============================================================================
`default_nettype none

module rc4_stream_cipher_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit CMD_KEY  = 1'b0;
    localparam bit CMD_DATA = 1'b1;

    localparam int TABLE_SIZE    = 256;
    localparam int MAX_KEY_BYTES = 256;
    localparam int RANDOM_ITEMS  = 500;
    localparam int QUIET_AFTER   = 440;
    // A key byte with tlast keeps the engine busy for a full key schedule.
    localparam int DRAIN_CYCLES  = 1200;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    rc4_stream_cipher #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // RC4 predictor state: the permutation table, the key bytes of the key
    // being loaded, and the two generator indices.
    // ------------------------------------------------------------------------
    logic [7:0] perm_tbl [TABLE_SIZE];
    logic [7:0] key_mem  [TABLE_SIZE];
    int         key_len;
    logic [7:0] gen_i;
    logic [7:0] gen_j;

    logic [7:0] cipher_expect_q [$];
    bit         failed;
    bit         quiet;
    int         items_sent;

    // The key schedule: identity table, then 256 swaps driven by the key
    // bytes taken cyclically over the loaded length.
    function automatic void schedule_key();
        int         pos;
        logic [7:0] acc;
        logic [7:0] kb;
        logic [7:0] tmp;
        pos = 0;
        acc = 8'd0;
        for (int n = 0; n < TABLE_SIZE; n++)
            perm_tbl[n] = n[7:0];
        for (int n = 0; n < TABLE_SIZE; n++)
        begin
            kb = 8'd0;
            if (key_len != 0)
            begin
                kb = key_mem[pos];
                pos++;
                if (pos >= key_len)
                    pos = 0;
            end
            acc = acc + perm_tbl[n] + kb;
            tmp = perm_tbl[n];
            perm_tbl[n] = perm_tbl[acc];
            perm_tbl[acc] = tmp;
        end
        gen_i   = 8'd0;
        gen_j   = 8'd0;
        key_len = 0;
    endfunction

    // Applies one accepted item to the predictor. A data item returns its
    // cipher byte; a key item returns nothing.
    function automatic bit cipher_step(input bit cmd, input logic [7:0] kbyte,
                                       input bit last, input logic [7:0] dbyte,
                                       output logic [7:0] cipher);
        logic [7:0] tmp;
        logic [7:0] r;
        cipher = 8'd0;
        if (cmd == CMD_KEY)
        begin
            // Bytes past the key store's capacity are dropped silently.
            if (key_len < MAX_KEY_BYTES && key_len < TABLE_SIZE)
            begin
                key_mem[key_len] = kbyte;
                key_len++;
            end
            if (last)
                schedule_key();
            return 1'b0;
        end
        gen_i = gen_i + 8'd1;
        gen_j = gen_j + perm_tbl[gen_i];
        tmp = perm_tbl[gen_i];
        perm_tbl[gen_i] = perm_tbl[gen_j];
        perm_tbl[gen_j] = tmp;
        r = perm_tbl[gen_i] + perm_tbl[gen_j];
        cipher = dbyte ^ perm_tbl[r];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Called at a falling edge; returns at the falling edge after
    // the item was accepted. When a typed value is given, it is queued in
    // place of the predicted cipher byte.
    // ------------------------------------------------------------------------
    task automatic send_item(input bit cmd, input logic [7:0] kbyte, input bit last,
                             input logic [7:0] dbyte, input bit typed,
                             input logic [7:0] typed_val);
        logic [7:0] cipher;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tlast  <= last;
        s_tdata  <= {dbyte, kbyte};
        do
            @(posedge clk);
        while (!s_tready);
        if (cipher_step(cmd, kbyte, last, dbyte, cipher))
            cipher_expect_q.push_back(typed ? typed_val : cipher);
        items_sent++;
        if (items_sent >= QUIET_AFTER)
            quiet = 1'b1;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall bursts on tready, none during the quiet tail.
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Every accepted output byte is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cipher_expect_q.size() == 0)
            begin
                $error("out_byte: expected none, actual %02h", m_tdata);
                failed = 1'b1;
            end
            else
            begin
                logic [7:0] want;
                want = cipher_expect_q.pop_front();
                if (m_tdata !== want)
                begin
                    $error("out_byte: expected %02h, actual %02h", want, m_tdata);
                    failed = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table. Each row is repeated reps times, with the key and data
    // bytes stepping by one per repetition. Rows with a typed value are the
    // first keystream bytes after reset, where the table is still the
    // identity: keystream bytes 2, 5 and 7.
    // ------------------------------------------------------------------------
    typedef struct {
        bit         cmd;
        logic [7:0] kbyte;
        bit         last;
        logic [7:0] dbyte;
        int         reps;
        bit         typed;
        logic [7:0] want;
    } stim_row_t;

    localparam int N_ROWS = 14;

    stim_row_t stim_tbl [N_ROWS] = '{
        // Reset keystream, all-zero, all-one and alternating-bit data, key fields set but ignored.
        '{CMD_DATA, 8'h00, 1'b0, 8'h00, 1, 1'b1, 8'h02},
        '{CMD_DATA, 8'hFF, 1'b1, 8'hFF, 1, 1'b1, 8'hFA},
        '{CMD_DATA, 8'h00, 1'b0, 8'h55, 1, 1'b1, 8'h52},
        // Single zero key byte; its data field is ignored.
        '{CMD_KEY,  8'h00, 1'b1, 8'hFF, 1, 1'b0, 8'h00},
        '{CMD_DATA, 8'hFF, 1'b1, 8'h00, 2, 1'b0, 8'h00},
        // Single all-ones key byte.
        '{CMD_KEY,  8'hFF, 1'b1, 8'h00, 1, 1'b0, 8'h00},
        '{CMD_DATA, 8'h00, 1'b0, 8'hFF, 2, 1'b0, 8'h00},
        // Five-byte key.
        '{CMD_KEY,  8'h01, 1'b0, 8'hAA, 4, 1'b0, 8'h00},
        '{CMD_KEY,  8'h80, 1'b1, 8'h55, 1, 1'b0, 8'h00},
        '{CMD_DATA, 8'h5A, 1'b0, 8'hA5, 3, 1'b0, 8'h00},
        // Rekey started in mid-stream, with a data item inside the key load.
        '{CMD_KEY,  8'h3C, 1'b0, 8'h00, 2, 1'b0, 8'h00},
        '{CMD_DATA, 8'h00, 1'b0, 8'h0F, 1, 1'b0, 8'h00},
        '{CMD_KEY,  8'hC3, 1'b1, 8'h00, 1, 1'b0, 8'h00},
        '{CMD_DATA, 8'h00, 1'b0, 8'hF0, 2, 1'b0, 8'h00}
    };

    // ------------------------------------------------------------------------
    // Main stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        int seq_no;
        int klen;
        int dlen;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 16'h0000;
        s_tuser  = CMD_KEY;
        s_tlast  = 1'b0;
        failed   = 1'b0;
        quiet    = 1'b0;
        key_len  = 0;
        gen_i    = 8'd0;
        gen_j    = 8'd0;
        for (int n = 0; n < TABLE_SIZE; n++)
        begin
            perm_tbl[n] = n[7:0];
            key_mem[n]  = 8'd0;
        end

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_tbl[r])
            for (int k = 0; k < stim_tbl[r].reps; k++)
                send_item(stim_tbl[r].cmd, stim_tbl[r].kbyte + k[7:0],
                          stim_tbl[r].last, stim_tbl[r].dbyte + k[7:0],
                          stim_tbl[r].typed, stim_tbl[r].want);

        // Random part: mostly a complete key load followed by a data burst.
        // The first sequence uses an overlong key: its first 256 bytes fill
        // the key store completely and its marking byte falls past it.
        items_sent = 0;
        seq_no     = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (seq_no < 1 || $urandom_range(0, 4) != 0)
            begin
                if (seq_no == 0)
                    klen = 258;
                else if ($urandom_range(0, 15) == 0)
                    klen = $urandom_range(17, 256);
                else
                    klen = $urandom_range(1, 16);
                for (int k = 0; k < klen; k++)
                    send_item(CMD_KEY, 8'($urandom_range(0, 255)), k == klen - 1,
                              8'($urandom_range(0, 255)), 1'b0, 8'h00);
                dlen = $urandom_range(1, 40);
                for (int k = 0; k < dlen; k++)
                    send_item(CMD_DATA, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 1'b0, 8'h00);
            end
            else
            begin
                // Noise: loose items, including partial keys and stray tlast.
                dlen = $urandom_range(1, 8);
                for (int k = 0; k < dlen; k++)
                    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              $urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)),
                              1'b0, 8'h00);
            end
            seq_no++;
        end

        quiet = 1'b1;
        s_tvalid <= 1'b0;
        while (cipher_expect_q.size() != 0)
            @(posedge clk);
        // Let a trailing key schedule finish so that stray output shows up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!failed && cipher_expect_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every item
    // triggering a full key schedule.
    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
